// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the evaluator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gf2anf_pkg.sv =====
// Shared types and constants of the GF(2) ANF polynomial evaluator
package gf2anf_pkg;

    localparam int MASK_W       = 16;
    localparam int CFG_W        = 5;
    localparam int DEF_MAX_VARS = 16;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [CFG_W-1:0] NUM_VARS_RST = 5'd16;
    localparam logic [CFG_W-1:0] MAX_DEG_RST  = 5'd16;

    typedef logic [1:0] t_op;
    localparam t_op OP_SET  = 2'd0;
    localparam t_op OP_XOR  = 2'd1;
    localparam t_op OP_EVAL = 2'd2;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NUM_VARS = 1'b0;
    localparam t_cfg_idx CFG_MAX_DEG  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_XOR_RD,
        ST_XOR_WR,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic set_now;
        logic xor_wr;
        logic eval_start;
        logic walk_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_zero;
    } t_dp_sts;

endpackage

// ===== rtl/gf2anf_dp.sv =====
// Datapath: coefficient memory, configuration registers, subset walker, parity
module gf2anf_dp #(
    parameter int MAX_VARS = gf2anf_pkg::DEF_MAX_VARS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  gf2anf_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [gf2anf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [gf2anf_pkg::MASK_W-1:0]  i_mask,
    input  logic                           i_bit,
    input  gf2anf_pkg::t_dp_cmd            i_cmd,
    output gf2anf_pkg::t_dp_sts            o_sts,
    output logic                           o_eval_bit
);
    import gf2anf_pkg::*;

    localparam int AW = MAX_VARS;

    function automatic logic [AW-1:0] to_idx(input logic [MASK_W-1:0] v);
        logic [AW+MASK_W-1:0] w;
        w = {{AW{1'b0}}, v};
        return w[AW-1:0];
    endfunction

    logic              r_store [2**AW];
    logic [CFG_W-1:0]  r_num_vars;
    logic [CFG_W-1:0]  r_max_deg;
    logic [AW-1:0]     r_clr_cnt;
    logic [AW-1:0]     r_idx;
    logic              r_bit;
    logic [MASK_W-1:0] r_span;
    logic [MASK_W-1:0] r_walk;
    logic              r_ok;
    logic              r_pend;
    logic              r_acc;
    logic              r_rdata;
    logic              r_eval_bit;

    logic [MASK_W-1:0] vars;
    logic [MASK_W-1:0] span;
    logic [CFG_W-1:0]  weight;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic              wdata;
    logic              we;

    // variables in use: below both num_vars and the store's width
    for (genvar g = 0; g < MASK_W; g++) begin : g_vars
        if (g < MAX_VARS) begin : g_in
            assign vars[g] = (r_num_vars > CFG_W'(g));
        end else begin : g_out
            assign vars[g] = 1'b0;
        end
    end

    assign span   = i_mask & vars;
    assign weight = CFG_W'($countones(r_walk));

    always_comb begin
        raddr = i_cmd.walk_step ? to_idx(r_walk) : r_idx;
        we    = 1'b0;
        waddr = r_idx;
        wdata = 1'b0;
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_clr_cnt;
        end else if (i_cmd.set_now) begin
            we    = 1'b1;
            waddr = to_idx(i_mask);
            wdata = i_bit;
        end else if (i_cmd.xor_wr) begin
            we    = 1'b1;
            wdata = r_rdata ^ r_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
        r_rdata <= r_store[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= NUM_VARS_RST;
            r_max_deg  <= MAX_DEG_RST;
            r_clr_cnt  <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NUM_VARS: r_num_vars <= i_cfg_data;
                    CFG_MAX_DEG:  r_max_deg  <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            r_pend <= i_cmd.walk_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= to_idx(i_mask);
            r_bit <= i_bit;
        end
        if (i_cmd.eval_start) begin
            r_span <= span;
            r_walk <= span;
            r_acc  <= 1'b0;
        end else if (r_pend && r_ok) begin
            r_acc <= r_acc ^ r_rdata;
        end
        if (i_cmd.walk_step) begin
            // step down to the next subset of the point
            r_walk <= (r_walk - MASK_W'(1)) & r_span;
            r_ok   <= (weight <= r_max_deg);
        end
        if (i_cmd.load_out) begin
            r_eval_bit <= r_acc;
        end
    end

    assign o_sts.clr_last  = &r_clr_cnt;
    assign o_sts.walk_zero = (r_walk == '0);
    assign o_eval_bit      = r_eval_bit;

endmodule

// ===== rtl/gf2anf_ctrl.sv =====
// Controller: sequences clearing, coefficient writes and evaluation walks
module gf2anf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gf2anf_pkg::t_op      i_op,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output gf2anf_pkg::t_dp_cmd  o_cmd,
    input  gf2anf_pkg::t_dp_sts  i_sts
);
    import gf2anf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_op)
                        OP_SET: o_cmd.set_now = 1'b1;
                        OP_XOR: n_state = ST_XOR_RD;
                        OP_EVAL: begin
                            o_cmd.eval_start = 1'b1;
                            n_state          = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_XOR_RD: n_state = ST_XOR_WR;
            ST_XOR_WR: begin
                o_cmd.xor_wr = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_zero) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/gf2_anf_poly_evaluator.sv =====
// Top level of the GF(2) algebraic normal form polynomial evaluator
//
// Input stream: one transaction per operation. tuser carries the operation
// (set coefficient, xor into coefficient, evaluate); tdata carries the mask
// and the coefficient bit. Output stream: one transaction per evaluation,
// eval_bit in tdata bit 0. Writes return nothing.
// Configuration: the user writes num_vars (index 0) and max_degree (index 1)
// through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle; the block
// itself does not enforce this.
// Operations: set writes the coefficient in the cycle it is accepted; xor
// reads the coefficient, then writes it back. Evaluation walks every subset
// of the point limited to num_vars variables, one memory read per cycle.
// Reset: a synchronous low reset starts a clearing pass that zeroes the store
// one entry per cycle, with tready held low throughout.
// Stall: the result waits in an output register; the next operations are
// still taken, and a new result waits until the held one has been taken.
module gf2_anf_poly_evaluator #(
    parameter int MAX_VARS = gf2anf_pkg::DEF_MAX_VARS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  gf2anf_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [gf2anf_pkg::CFG_W-1:0]       i_cfg_data,
    // operation stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [gf2anf_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [15:0] mask, [16] bit_value
    input  gf2anf_pkg::t_op                    i_s_axis_tuser,  // [1:0] operation
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [gf2anf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata   // [0] eval_bit
);
    import gf2anf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    eval_bit;

    gf2anf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gf2anf_dp #(
        .MAX_VARS (MAX_VARS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mask     (i_s_axis_tdata[MASK_W-1:0]),
        .i_bit      (i_s_axis_tdata[MASK_W]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_eval_bit (eval_bit)
    );

    // pad the single result bit to a whole byte
    assign o_m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, eval_bit};

endmodule

// ===== rtl/gf2anf_chk.sv =====
// Port-level checker for the evaluator, bound to the top level
`include "assert_macros.svh"

module gf2anf_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_we,
    input gf2anf_pkg::t_cfg_idx               i_cfg_idx,
    input logic [gf2anf_pkg::CFG_W-1:0]       i_cfg_data,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [gf2anf_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input gf2anf_pkg::t_op                    i_s_axis_tuser,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [gf2anf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import gf2anf_pkg::*;

    logic in_acc;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // after a reset edge: clearing, so nothing is taken and nothing offered
    `ASSERT_CLK(a_reset_quiet, i_clk,
        !i_rst_n |=> (!o_s_axis_tready && !o_m_axis_tvalid),
        "input ready or output valid right after reset")

    // a held result stays offered until taken
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)),
        "result dropped or changed while stalled")

    // a write never produces a result
    `ASSERT_CLK_RST(a_write_silent, i_clk, i_rst_n,
        (in_acc && i_s_axis_tuser != OP_EVAL && !o_m_axis_tvalid) |=> !o_m_axis_tvalid,
        "result appeared after a write")

    // xor and evaluate occupy the block for at least the next cycle
    `ASSERT_CLK_RST(a_busy_after_op, i_clk, i_rst_n,
        (in_acc && (i_s_axis_tuser == OP_XOR || i_s_axis_tuser == OP_EVAL)) |=>
            !o_s_axis_tready,
        "input ready directly after a multi-cycle operation")

endmodule

bind gf2_anf_poly_evaluator gf2anf_chk u_chk (.*);
